// ----- hw/rtl/sfq_pkg.sv -----
package sfq_pkg;

    localparam int DEFAULT_DEPTH = 16;

    localparam int OP_W     = 3;
    localparam int CODE_W   = 16;
    localparam int PLATE_W  = 56;
    localparam int TYPE_W   = 2;
    localparam int PRICE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    localparam logic [TYPE_W-1:0] TYPE_LIGHT  = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_MEDIUM = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_HEAVY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PRICE_LIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRICE_MEDIUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRICE_HEAVY  = 2'd2;

    // fares in cents: 2.50, 5.00, 7.50
    localparam logic [PRICE_W-1:0] PRICE_LIGHT_RST  = 16'd250;
    localparam logic [PRICE_W-1:0] PRICE_MEDIUM_RST = 16'd500;
    localparam logic [PRICE_W-1:0] PRICE_HEAVY_RST  = 16'd750;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [PLATE_W-1:0] plate;
        logic [TYPE_W-1:0]  vtype;
        logic [PRICE_W-1:0] price;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [PRICE_W-1:0] light;
        logic [PRICE_W-1:0] mid;
        logic [PRICE_W-1:0] heavy;
    } t_prices;

    function automatic logic [PRICE_W-1:0] fare_of(t_prices prices, logic [TYPE_W-1:0] vtype);
        logic [PRICE_W-1:0] fare;
        case (vtype)
            TYPE_LIGHT:  fare = prices.light;
            TYPE_MEDIUM: fare = prices.mid;
            TYPE_HEAVY:  fare = prices.heavy;
            default:     fare = '0;
        endcase
        return fare;
    endfunction

endpackage

// ----- hw/rtl/searchable_fifo_queue_top.sv -----
// Bounded FIFO of vehicle entries (code, packed plate, type, fare) held in one
// synchronous RAM of QUEUE_DEPTH words. One item is in work at a time: each
// accepted item passes the execute state and then the push state, which loads
// the output register once that is empty or not stalled; a dequeue also passes
// the dequeue state, which takes the RAM read, and a search the scan state, which
// compares at most as many entries as the queue holds, one RAM read per cycle
// from head toward tail. The next item is accepted after the push. A finished item waits in
// the output register while the next item is accepted. Fares come from three
// price registers written through the configuration port; a type of 0 stores
// fare 0. Found fields are zero unless a dequeue or search returns status ok.
module searchable_fifo_queue_top #(
    parameter int QUEUE_DEPTH = sfq_pkg::DEFAULT_DEPTH,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sfq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sfq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sfq_pkg::OP_W-1:0]          i_operation,
    input  logic [sfq_pkg::CODE_W-1:0]        i_vehicle_code,
    input  logic [sfq_pkg::PLATE_W-1:0]       i_vehicle_plate,
    input  logic [sfq_pkg::TYPE_W-1:0]        i_vehicle_type,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sfq_pkg::STATUS_W-1:0]      o_status,
    output logic [sfq_pkg::CODE_W-1:0]        o_found_code,
    output logic [sfq_pkg::PLATE_W-1:0]       o_found_plate,
    output logic [sfq_pkg::TYPE_W-1:0]        o_found_type,
    output logic [sfq_pkg::PRICE_W-1:0]       o_found_price,
    output logic [CNT_W-1:0]                  o_occupancy
);

    sfq_pkg::t_prices                prices;
    sfq_pkg::t_entry                 out_entry;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [sfq_pkg::ENTRY_W-1:0]     wr_data;
    logic                            rd_en;
    logic [IDX_W-1:0]                rd_addr;
    logic [sfq_pkg::ENTRY_W-1:0]     rd_data;

    sfq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_prices    (prices)
    );

    sfq_ram #(
        .WIDTH (sfq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sfq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_prices        (prices),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_vehicle_code  (i_vehicle_code),
        .i_vehicle_plate (i_vehicle_plate),
        .i_vehicle_type  (i_vehicle_type),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_entry         (out_entry),
        .o_occupancy     (o_occupancy),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data)
    );

    assign o_found_code  = out_entry.code;
    assign o_found_plate = out_entry.plate;
    assign o_found_type  = out_entry.vtype;
    assign o_found_price = out_entry.price;

endmodule

// ----- hw/rtl/sfq_ram.sv -----
module sfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/sfq_cfg.sv -----
module sfq_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sfq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sfq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output sfq_pkg::t_prices                   o_prices
);

    sfq_pkg::t_prices r_prices;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prices.light <= sfq_pkg::PRICE_LIGHT_RST;
            r_prices.mid   <= sfq_pkg::PRICE_MEDIUM_RST;
            r_prices.heavy <= sfq_pkg::PRICE_HEAVY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfq_pkg::REG_PRICE_LIGHT:  r_prices.light <= i_cfg_data;
                sfq_pkg::REG_PRICE_MEDIUM: r_prices.mid   <= i_cfg_data;
                sfq_pkg::REG_PRICE_HEAVY:  r_prices.heavy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_prices = r_prices;

endmodule

// ----- hw/rtl/sfq_ctrl.sv -----
module sfq_ctrl #(
    parameter int QUEUE_DEPTH = sfq_pkg::DEFAULT_DEPTH,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sfq_pkg::t_prices                  i_prices,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sfq_pkg::OP_W-1:0]          i_operation,
    input  logic [sfq_pkg::CODE_W-1:0]        i_vehicle_code,
    input  logic [sfq_pkg::PLATE_W-1:0]       i_vehicle_plate,
    input  logic [sfq_pkg::TYPE_W-1:0]        i_vehicle_type,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sfq_pkg::STATUS_W-1:0]      o_status,
    output sfq_pkg::t_entry                   o_entry,
    output logic [CNT_W-1:0]                  o_occupancy,
    output logic                              o_wr_en,
    output logic [IDX_W-1:0]                  o_wr_addr,
    output logic [sfq_pkg::ENTRY_W-1:0]       o_wr_data,
    output logic                              o_rd_en,
    output logic [IDX_W-1:0]                  o_rd_addr,
    input  logic [sfq_pkg::ENTRY_W-1:0]       i_rd_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DEQ  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    function automatic logic [IDX_W-1:0] wrap_next(logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    logic [2:0]                    r_state, n_state;
    logic [sfq_pkg::OP_W-1:0]      r_op;
    logic [sfq_pkg::CODE_W-1:0]    r_key;
    logic [sfq_pkg::PLATE_W-1:0]   r_plate;
    logic [sfq_pkg::TYPE_W-1:0]    r_type;
    logic [IDX_W-1:0]              r_head, n_head;
    logic [IDX_W-1:0]              r_tail, n_tail;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [IDX_W-1:0]              r_slot, n_slot;
    logic [CNT_W-1:0]              r_left, n_left;
    logic [sfq_pkg::STATUS_W-1:0]  r_res_status, n_res_status;
    sfq_pkg::t_entry               r_res_entry, n_res_entry;
    logic                          r_out_valid, n_out_valid;
    logic [sfq_pkg::STATUS_W-1:0]  r_out_status;
    sfq_pkg::t_entry               r_out_entry;
    logic [CNT_W-1:0]              r_out_occ;
    logic                          out_load;
    logic                          in_accept;
    sfq_pkg::t_entry               rd_entry;
    sfq_pkg::t_entry               wr_entry;

    assign rd_entry   = sfq_pkg::t_entry'(i_rd_data);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_PUSH) && (!r_out_valid || !i_out_stall);

    always_comb begin
        wr_entry.code  = r_key;
        wr_entry.plate = r_plate;
        wr_entry.vtype = r_type;
        wr_entry.price = sfq_pkg::fare_of(i_prices, r_type);
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_slot       = r_slot;
        n_left       = r_left;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_tail;
        o_wr_data    = wr_entry;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_head;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = sfq_pkg::ST_OK;
                n_res_entry  = '0;
                n_state      = S_PUSH;
                case (r_op)
                    sfq_pkg::OP_ENQUEUE: begin
                        if (r_count == FULL_CNT) begin
                            n_res_status = sfq_pkg::ST_FULL;
                        end else begin
                            o_wr_en = 1'b1;
                            n_tail  = wrap_next(r_tail);
                            n_count = r_count + 1'b1;
                        end
                    end
                    sfq_pkg::OP_DEQUEUE: begin
                        if (r_count == '0) begin
                            n_res_status = sfq_pkg::ST_EMPTY;
                        end else begin
                            o_rd_en = 1'b1;
                            n_state = S_DEQ;
                        end
                    end
                    sfq_pkg::OP_CLEAR: begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                    end
                    sfq_pkg::OP_SEARCH: begin
                        if (r_count == '0) begin
                            n_res_status = sfq_pkg::ST_EMPTY;
                        end else begin
                            // first read at head; later reads overlap the compare
                            o_rd_en = 1'b1;
                            n_slot  = wrap_next(r_head);
                            n_left  = r_count;
                            n_state = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            S_DEQ: begin
                n_res_entry = rd_entry;
                n_head      = wrap_next(r_head);
                n_count     = r_count - 1'b1;
                n_state     = S_PUSH;
            end
            S_SCAN: begin
                if (rd_entry.code == r_key) begin
                    n_res_entry = rd_entry;
                    n_state     = S_PUSH;
                end else if (r_left == CNT_W'(1)) begin
                    n_res_status = sfq_pkg::ST_NOTFOUND;
                    n_state      = S_PUSH;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_slot;
                    n_slot    = wrap_next(r_slot);
                    n_left    = r_left - 1'b1;
                end
            end
            S_PUSH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i_operation;
            r_key   <= i_vehicle_code;
            r_plate <= i_vehicle_plate;
            r_type  <= i_vehicle_type;
        end
        r_slot       <= n_slot;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_entry  <= r_res_entry;
            r_out_occ    <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_entry     = r_out_entry;
    assign o_occupancy = r_out_occ;

endmodule

// ----- hw/rtl/sfq_chk.sv -----
module sfq_chk #(
    parameter int QUEUE_DEPTH = sfq_pkg::DEFAULT_DEPTH,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [sfq_pkg::STATUS_W-1:0]      o_status,
    input logic [sfq_pkg::CODE_W-1:0]        o_found_code,
    input logic [sfq_pkg::PLATE_W-1:0]       o_found_plate,
    input logic [sfq_pkg::TYPE_W-1:0]        o_found_type,
    input logic [sfq_pkg::PRICE_W-1:0]       o_found_price,
    input logic [CNT_W-1:0]                  o_occupancy
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_occupancy) && $stable(o_found_code))
        else $error("stalled item changed");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_occupancy <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != sfq_pkg::ST_OK |->
            o_found_code == '0 && o_found_plate == '0 && o_found_type == '0
            && o_found_price == '0)
        else $error("entry fields set on error status");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == sfq_pkg::ST_FULL |-> o_occupancy == CNT_W'(QUEUE_DEPTH))
        else $error("full status without full queue");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == sfq_pkg::ST_EMPTY |-> o_occupancy == '0)
        else $error("empty status with entries present");

endmodule

bind searchable_fifo_queue_top sfq_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sfq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_found_code  (o_found_code),
    .o_found_plate (o_found_plate),
    .o_found_type  (o_found_type),
    .o_found_price (o_found_price),
    .o_occupancy   (o_occupancy)
);
